// ===== src/asps_pkg.sv =====
// ----------------------------------------------------------------------------
// asps_pkg
// Types, constants and the arctangent table shared by the annular sector
// pixel statistics unit.
// ----------------------------------------------------------------------------
package asps_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;
   localparam int QUEUE_DEPTH = 4;

   // CORDIC datapath widths: offsets scaled by 256, angles in Q4.30
   localparam int XW = 28;
   localparam int ZW = 34;

   localparam logic signed [16:0] PI_Q12      = 17'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [71:0] SAT_POS = {25'd0, {47{1'b1}}};

   localparam logic [2:0] MOM_SUM      = 3'd0;
   localparam logic [2:0] MOM_MEAN     = 3'd1;
   localparam logic [2:0] MOM_STD      = 3'd2;
   localparam logic [2:0] MOM_CONTRAST = 3'd3;
   localparam logic [2:0] MOM_XCENTER  = 3'd4;
   localparam logic [2:0] MOM_YCENTER  = 3'd5;

   typedef enum logic [2:0] {
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_INNER_RSQ,
      REG_OUTER_RSQ,
      REG_PHI_LOW,
      REG_PHI_HIGH,
      REG_PEDESTAL,
      REG_MOMENT
   } reg_index_type;

   typedef struct packed {
      logic [15:0]        center_x;
      logic [15:0]        center_y;
      logic [32:0]        inner_radius_sq;
      logic [32:0]        outer_radius_sq;
      logic signed [16:0] phi_low;
      logic signed [16:0] phi_high;
      logic [15:0]        pedestal;
      logic [2:0]         moment_select;
   } cfg_type;

   // one classified pixel on its way from front to back
   typedef struct packed {
      logic               keep;
      logic               last;
      logic [15:0]        n;
      logic signed [16:0] v;
      logic [32:0]        vsq;
      logic signed [29:0] cv;
      logic signed [29:0] rv;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
      logic signed [ZW-1:0] r;
      case (i)
         0:  r = 34'sd843314856;
         1:  r = 34'sd497837829;
         2:  r = 34'sd263043836;
         3:  r = 34'sd133525158;
         4:  r = 34'sd67021686;
         5:  r = 34'sd33543515;
         6:  r = 34'sd16775850;
         7:  r = 34'sd8388437;
         8:  r = 34'sd4194282;
         9:  r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         16: r = 34'sd16383;
         17: r = 34'sd8191;
         18: r = 34'sd4095;
         19: r = 34'sd2047;
         20: r = 34'sd1023;
         21: r = 34'sd511;
         22: r = 34'sd255;
         23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/asps_req_if.sv =====
// ----------------------------------------------------------------------------
// asps_req_if
// Pixel request channel: valid/ready handshake with the pixel fields.
// ----------------------------------------------------------------------------
interface asps_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] column;
   logic [11:0] row;
   logic [15:0] raw_value;
   logic        masked_out;
   logic        last_pixel;
   logic [15:0] norm_divisor;

   modport source (output valid, column, row, raw_value, masked_out, last_pixel,
                   norm_divisor, input ready);
   modport sink (input valid, column, row, raw_value, masked_out, last_pixel,
                 norm_divisor, output ready);
endinterface

// ===== src/asps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// asps_rsp_if
// Result channel: valid/ready handshake with one statistic per image.
// ----------------------------------------------------------------------------
interface asps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] result_value;
   logic [24:0]        pixel_count;
   logic               math_fault;

   modport source (output valid, result_value, pixel_count, math_fault, input ready);
   modport sink (input valid, result_value, pixel_count, math_fault, output ready);
endinterface

// ===== src/asps_front.sv =====
// ----------------------------------------------------------------------------
// asps_front
// Pixel pipeline: offset from centre, squared radius, CORDIC angle, region
// test and moment products. The whole pipe advances when the queue has room.
// ----------------------------------------------------------------------------
module asps_front #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  asps_pkg::cfg_type     cfg,
   asps_req_if.sink              req,
   input  asps_pkg::q_stat_type  q_stat,
   output logic                  q_push,
   output asps_pkg::item_type    q_item
);
   import asps_pkg::*;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
      logic [15:0] raw;
      logic        take;
      logic        last;
      logic [15:0] n;
      logic        flat;
      logic        flat_neg;
      logic [32:0] rsq;
   } side_type;

   typedef struct packed {
      logic               keep;
      logic               last;
      logic [15:0]        n;
      logic signed [16:0] v;
      logic [11:0]        col;
      logic [11:0]        row;
   } class_type;

   logic advance;

   // input stage
   logic               a_valid_ff, a_valid_in;
   side_type           a_side_ff, a_side_in;
   logic signed [17:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;

   // CORDIC stages, index 0 is after the quadrant fold
   logic                 v_ff [CORDIC_STAGES+1];
   logic                 v_in [CORDIC_STAGES+1];
   logic signed [XW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] x_in [CORDIC_STAGES+1];
   logic signed [XW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] y_in [CORDIC_STAGES+1];
   logic signed [ZW-1:0] z_ff [CORDIC_STAGES+1];
   logic signed [ZW-1:0] z_in [CORDIC_STAGES+1];
   side_type             s_ff [CORDIC_STAGES+1];
   side_type             s_in [CORDIC_STAGES+1];
   logic [31:0]          sqx_ff, sqx_in, sqy_ff, sqy_in;

   logic      f_valid_ff, f_valid_in;
   class_type f_ff, f_in;
   logic      g_valid_ff, g_valid_in;
   item_type  g_ff, g_in;

   assign advance   = !g_valid_ff || !q_stat.full;
   assign req.ready = advance;
   assign q_push    = g_valid_ff && !q_stat.full;
   assign q_item    = g_ff;

   always_comb begin
      a_valid_in       = req.valid;
      a_side_in        = '0;
      a_side_in.col    = req.column;
      a_side_in.row    = req.row;
      a_side_in.raw    = req.raw_value;
      a_side_in.last   = req.last_pixel;
      a_side_in.n      = req.norm_divisor;
      a_side_in.take   = !req.masked_out &&
                         ({3'b000, req.column} < 15'(MAX_COLUMNS)) &&
                         ({3'b000, req.row} < 15'(MAX_ROWS));
      a_dx_in = $signed({2'b00, req.column, 4'h8}) - $signed({2'b00, cfg.center_x});
      a_dy_in = $signed({2'b00, req.row, 4'h8}) - $signed({2'b00, cfg.center_y});
   end

   // quadrant fold into the right half plane
   always_comb begin
      logic signed [XW-1:0] x0, y0;
      logic signed [35:0]   dxsq, dysq;
      x0 = XW'(a_dx_ff) <<< 8;
      y0 = XW'(a_dy_ff) <<< 8;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            x_in[0] = y0;
            y_in[0] = -x0;
            z_in[0] = HALF_PI_Q30;
         end else begin
            x_in[0] = -y0;
            y_in[0] = x0;
            z_in[0] = -HALF_PI_Q30;
         end
      end else begin
         x_in[0] = x0;
         y_in[0] = y0;
         z_in[0] = '0;
      end
      dxsq = a_dx_ff * a_dx_ff;
      dysq = a_dy_ff * a_dy_ff;
      sqx_in = dxsq[31:0];
      sqy_in = dysq[31:0];
      s_in[0]          = a_side_ff;
      s_in[0].flat     = (a_dy_ff == 18'sd0);
      s_in[0].flat_neg = a_dx_ff[17];
      v_in[0]          = a_valid_ff;
   end

   for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_stage
      always_comb begin
         logic signed [XW-1:0] xs, ys;
         xs = x_ff[k-1] >>> (k - 1);
         ys = y_ff[k-1] >>> (k - 1);
         if (y_ff[k-1] > 0) begin
            x_in[k] = x_ff[k-1] + ys;
            y_in[k] = y_ff[k-1] - xs;
            z_in[k] = z_ff[k-1] + atan_q30(k - 1);
         end else begin
            x_in[k] = x_ff[k-1] - ys;
            y_in[k] = y_ff[k-1] + xs;
            z_in[k] = z_ff[k-1] - atan_q30(k - 1);
         end
         s_in[k] = s_ff[k-1];
         if (k == 1) begin
            s_in[k].rsq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
         end
         v_in[k] = v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_in[k];
         end
         if (advance) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            s_ff[k] <= s_in[k];
         end
      end
   end

   // region test on the finished angle
   always_comb begin
      side_type             sd;
      logic signed [ZW-1:0] zr;
      logic signed [16:0]   ang;
      logic signed [17:0]   a18, lo18, hi18;
      logic                 in_band, ang_ok;
      sd = s_ff[CORDIC_STAGES];
      zr = (z_ff[CORDIC_STAGES] + ZW'(131072)) >>> 18;
      if (sd.flat) begin
         ang = sd.flat_neg ? PI_Q12 : 17'sd0;
      end else if (zr > ZW'(PI_Q12)) begin
         ang = PI_Q12;
      end else if (zr < -ZW'(PI_Q12)) begin
         ang = -PI_Q12;
      end else begin
         ang = zr[16:0];
      end
      a18  = 18'(ang);
      lo18 = 18'(cfg.phi_low);
      hi18 = 18'(cfg.phi_high);
      in_band = (sd.rsq >= cfg.inner_radius_sq) && (sd.rsq <= cfg.outer_radius_sq);
      ang_ok  = ((a18 >= lo18) && (a18 <= hi18)) || ((a18 + TWO_PI_Q12) <= hi18);
      f_valid_in = v_ff[CORDIC_STAGES];
      f_in.keep  = sd.take && in_band && ang_ok;
      f_in.last  = sd.last;
      f_in.n     = sd.n;
      f_in.v     = $signed({1'b0, sd.raw}) - $signed({1'b0, cfg.pedestal});
      f_in.col   = sd.col;
      f_in.row   = sd.row;
   end

   always_comb begin
      logic signed [33:0] vsq;
      vsq        = f_ff.v * f_ff.v;
      g_valid_in = f_valid_ff;
      g_in.keep  = f_ff.keep;
      g_in.last  = f_ff.last;
      g_in.n     = f_ff.n;
      g_in.v     = f_ff.v;
      g_in.vsq   = vsq[32:0];
      g_in.cv    = $signed({1'b0, f_ff.col}) * f_ff.v;
      g_in.rv    = $signed({1'b0, f_ff.row}) * f_ff.v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         v_ff[0]    <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         v_ff[0]    <= v_in[0];
         f_valid_ff <= f_valid_in;
         g_valid_ff <= g_valid_in;
      end
      if (advance) begin
         a_side_ff <= a_side_in;
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         x_ff[0]   <= x_in[0];
         y_ff[0]   <= y_in[0];
         z_ff[0]   <= z_in[0];
         s_ff[0]   <= s_in[0];
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         f_ff      <= f_in;
         g_ff      <= g_in;
      end
   end

endmodule

// ===== src/asps_queue.sv =====
// ----------------------------------------------------------------------------
// asps_queue
// Short FIFO of classified pixels between the front pipe and the back end.
// ----------------------------------------------------------------------------
module asps_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  asps_pkg::item_type    push_item,
   input  logic                  pop,
   output asps_pkg::item_type    pop_item,
   output asps_pkg::q_stat_type  stat
);
   import asps_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CW'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign pop_item   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== src/asps_back.sv =====
// ----------------------------------------------------------------------------
// asps_back
// Accumulates kept pixels and, on the last pixel of an image, works out the
// selected statistic with a shift-add multiplier, a bitwise square root and
// a restoring divider.
// ----------------------------------------------------------------------------
module asps_back (
   input  logic                  clock,
   input  logic                  reset,
   input  asps_pkg::cfg_type     cfg,
   input  asps_pkg::item_type    q_item,
   input  asps_pkg::q_stat_type  q_stat,
   output logic                  q_pop,
   asps_rsp_if.source            rsp
);
   import asps_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_MUL_QC,
      ST_MUL_S2,
      ST_CHECK,
      ST_SQRT,
      ST_ROUND,
      ST_DIV,
      ST_NEXT,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [24:0]        cnt_ff, cnt_in;
   logic signed [40:0] sum_ff, sum_in;
   logic [57:0]        sq_ff, sq_in;
   logic signed [53:0] cws_ff, cws_in, rws_ff, rws_in;
   logic [15:0]        n_ff, n_in;
   logic [83:0]        ma_ff, ma_in, prod_ff, prod_in, qc_ff, qc_in;
   logic [40:0]        mb_ff, mb_in;
   logic [115:0]       sr_ff, sr_in;
   logic [59:0]        rem_ff, rem_in;
   logic [57:0]        root_ff, root_in;
   logic [71:0]        num_ff, num_in, quo_ff, quo_in;
   logic [40:0]        dvs_ff, dvs_in, drem_ff, drem_in;
   logic [6:0]         ctr_ff, ctr_in;
   logic               neg_ff, neg_in, second_ff, second_in;
   logic signed [47:0] res_ff, res_in;
   logic               fault_ff, fault_in;

   logic [40:0]        sm;
   logic [15:0]        nn;
   logic signed [53:0] w;
   logic [53:0]        wmag;
   logic [83:0]        prod_step;
   logic [57:0]        root_step;

   assign sm   = sum_ff[40] ? 41'(-sum_ff) : 41'(sum_ff);
   assign nn   = (n_ff == '0) ? 16'd1 : n_ff;
   assign w    = (cfg.moment_select == MOM_XCENTER) ? cws_ff : rws_ff;
   assign wmag = w[53] ? 54'(-w) : 54'(w);

   assign q_pop            = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp.valid        = (state_ff == ST_OUT);
   assign rsp.result_value = res_ff;
   assign rsp.pixel_count  = cnt_ff;
   assign rsp.math_fault   = fault_ff;

   always_comb begin
      logic [61:0] rem_s;
      logic [59:0] trial;
      logic [41:0] t;
      logic        ge;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      cws_in    = cws_ff;
      rws_in    = rws_ff;
      n_in      = n_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      qc_in     = qc_ff;
      sr_in     = sr_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      drem_in   = drem_ff;
      ctr_in    = ctr_ff;
      neg_in    = neg_ff;
      second_in = second_ff;
      res_in    = res_ff;
      fault_in  = fault_ff;

      // one shift-add step of the multiplier
      prod_step = mb_ff[0] ? prod_ff + ma_ff : prod_ff;

      // one digit of the square root
      rem_s = {rem_ff, sr_ff[115:114]};
      trial = {root_ff, 2'b01};
      if (rem_s >= {2'b00, trial}) begin
         root_step = {root_ff[56:0], 1'b1};
      end else begin
         root_step = {root_ff[56:0], 1'b0};
      end

      // one bit of the divider
      t  = {drem_ff, num_ff[71]};
      ge = (t >= {1'b0, dvs_ff});

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               if (q_item.keep) begin
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + 41'(q_item.v);
                  sq_in  = sq_ff + 58'(q_item.vsq);
                  cws_in = cws_ff + 54'(q_item.cv);
                  rws_in = rws_ff + 54'(q_item.rv);
               end
               if (q_item.last) begin
                  n_in     = q_item.n;
                  state_in = ST_PLAN;
               end
            end
         end
         ST_PLAN: begin
            second_in = 1'b0;
            fault_in  = 1'b0;
            res_in    = '0;
            neg_in    = 1'b0;
            unique case (cfg.moment_select)
               MOM_SUM: begin
                  num_in   = {15'd0, sm, 16'd0};
                  dvs_in   = {25'd0, nn};
                  neg_in   = sum_ff[40];
                  state_in = ST_ROUND;
               end
               MOM_MEAN: begin
                  if (cnt_ff == '0) begin
                     fault_in = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     num_in   = {15'd0, sm, 16'd0};
                     dvs_in   = cnt_ff * nn;
                     neg_in   = sum_ff[40];
                     state_in = ST_ROUND;
                  end
               end
               MOM_STD, MOM_CONTRAST: begin
                  if ((cfg.moment_select == MOM_STD) ? (cnt_ff == '0) : (sm == '0)) begin
                     fault_in = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     ma_in    = 84'(sq_ff);
                     mb_in    = 41'(cnt_ff);
                     prod_in  = '0;
                     ctr_in   = 7'd41;
                     state_in = ST_MUL_QC;
                  end
               end
               MOM_XCENTER, MOM_YCENTER: begin
                  if (sm == '0) begin
                     fault_in = 1'b1;
                     state_in = ST_OUT;
                  end else begin
                     num_in   = {2'b00, wmag, 16'd0};
                     dvs_in   = sm;
                     neg_in   = w[53] ^ sum_ff[40];
                     state_in = ST_ROUND;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_MUL_QC: begin
            prod_in = prod_step;
            ma_in   = {ma_ff[82:0], 1'b0};
            mb_in   = {1'b0, mb_ff[40:1]};
            ctr_in  = ctr_ff - 1'b1;
            if (ctr_ff == 7'd1) begin
               qc_in    = prod_step;
               ma_in    = 84'(sm);
               mb_in    = sm;
               prod_in  = '0;
               ctr_in   = 7'd41;
               state_in = ST_MUL_S2;
            end
         end
         ST_MUL_S2: begin
            prod_in = prod_step;
            ma_in   = {ma_ff[82:0], 1'b0};
            mb_in   = {1'b0, mb_ff[40:1]};
            ctr_in  = ctr_ff - 1'b1;
            if (ctr_ff == 7'd1) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // a negative variance term only comes from wrapped sums
            if (qc_ff < prod_ff) begin
               fault_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               sr_in    = {qc_ff - prod_ff, 32'd0};
               rem_in   = '0;
               root_in  = '0;
               ctr_in   = 7'd58;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rem_s >= {2'b00, trial}) begin
               rem_in = 60'(rem_s - {2'b00, trial});
            end else begin
               rem_in = rem_s[59:0];
            end
            root_in = root_step;
            sr_in   = {sr_ff[113:0], 2'b00};
            ctr_in  = ctr_ff - 1'b1;
            if (ctr_ff == 7'd1) begin
               num_in   = 72'(root_step);
               dvs_in   = (cfg.moment_select == MOM_STD) ? 41'(cnt_ff) : sm;
               drem_in  = '0;
               quo_in   = '0;
               ctr_in   = 7'd72;
               state_in = ST_DIV;
            end
         end
         ST_ROUND: begin
            // add half the divisor so the floor divide rounds to nearest
            num_in   = num_ff + 72'(dvs_ff >> 1);
            drem_in  = '0;
            quo_in   = '0;
            ctr_in   = 7'd72;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            drem_in = ge ? 41'(t - {1'b0, dvs_ff}) : t[40:0];
            quo_in  = {quo_ff[70:0], ge};
            num_in  = {num_ff[70:0], 1'b0};
            ctr_in  = ctr_ff - 1'b1;
            if (ctr_ff == 7'd1) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if ((cfg.moment_select == MOM_STD) && !second_ff && (n_ff != '0)) begin
               num_in    = quo_ff;
               dvs_in    = 41'(n_ff);
               second_in = 1'b1;
               state_in  = ST_ROUND;
            end else begin
               if (quo_ff > SAT_POS) begin
                  res_in = neg_ff ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  res_in = neg_ff ? -$signed(quo_ff[47:0]) : $signed(quo_ff[47:0]);
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               cnt_in   = '0;
               sum_in   = '0;
               sq_in    = '0;
               cws_in   = '0;
               rws_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         cws_ff   <= '0;
         rws_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         cws_ff   <= cws_in;
         rws_ff   <= rws_in;
      end
      n_ff      <= n_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      prod_ff   <= prod_in;
      qc_ff     <= qc_in;
      sr_ff     <= sr_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      drem_ff   <= drem_in;
      ctr_ff    <= ctr_in;
      neg_ff    <= neg_in;
      second_ff <= second_in;
      res_ff    <= res_in;
      fault_ff  <= fault_in;
   end

endmodule

// ===== src/annular_sector_pixel_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// annular_sector_pixel_statistics_unit
// Per-image statistics over the pixels that fall in a ring sector.
// ----------------------------------------------------------------------------
// Pixels enter one per clock until the queue fills, then ready is held low.
// Each request passes a pipe of CORDIC_STAGES + 4 registers (offset, quadrant
// fold, one stage per CORDIC iteration, region test, moment products) into a
// four-entry queue; the back end folds one queued pixel a cycle into the
// accumulators while idle. The last pixel of an image makes it compute the
// result with multi-cycle units: sum, mean and the centroids use a divide
// (one divider bit a cycle), standard deviation and contrast also two 41-step
// shift-add products and a 58-step square root, plus a second divide for the
// standard deviation when a normalisation is given. The user must write
// configuration only while no image is in flight; the block does not check it.
module annular_sector_pixel_statistics_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   asps_req_if.sink    req_bus,
   asps_rsp_if.source  rsp_bus,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [32:0] csr_data
);
   import asps_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   push_item, pop_item;
   q_stat_type q_stat;
   logic       q_push, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_CENTER_X:  cfg_in.center_x        = csr_data[15:0];
            REG_CENTER_Y:  cfg_in.center_y        = csr_data[15:0];
            REG_INNER_RSQ: cfg_in.inner_radius_sq = csr_data;
            REG_OUTER_RSQ: cfg_in.outer_radius_sq = csr_data;
            REG_PHI_LOW:   cfg_in.phi_low         = csr_data[16:0];
            REG_PHI_HIGH:  cfg_in.phi_high        = csr_data[16:0];
            REG_PEDESTAL:  cfg_in.pedestal        = csr_data[15:0];
            REG_MOMENT:    cfg_in.moment_select   = csr_data[2:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x        <= '0;
         cfg_ff.center_y        <= '0;
         cfg_ff.inner_radius_sq <= '0;
         cfg_ff.outer_radius_sq <= '1;
         cfg_ff.phi_low         <= -PI_Q12;
         cfg_ff.phi_high        <= PI_Q12;
         cfg_ff.pedestal        <= '0;
         cfg_ff.moment_select   <= MOM_SUM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asps_front #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_bus),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_item (push_item)
   );

   asps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   asps_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_item (pop_item),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .rsp    (rsp_bus)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

   a_hold_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !q_pop)
      else $error("pixel taken while a result is pending");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready) |=> !rsp_bus.valid)
      else $error("result repeated after delivery");

endmodule

// ===== tb/sv/asps_stats_checker.sv =====
// ----------------------------------------------------------------------------
// asps_stats_checker
// Watches the pixel, result and register ports of the annular sector
// statistics unit, keeps its own model of the accumulators and the selected
// statistic, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module asps_stats_checker
   import asps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   asps_req_if         req_bus,
   asps_rsp_if         rsp_bus,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [32:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [47:0] value;
      logic [24:0]        count;
      logic               fault;
   } image_stat_type;

   cfg_type            cfg;
   logic [24:0]        acc_count;
   logic signed [40:0] acc_sum;
   logic [57:0]        acc_sq;
   logic signed [53:0] acc_cw;
   logic signed [53:0] acc_rw;
   image_stat_type     stat_q[$];
   longint             atan_tbl[16];

   initial begin
      atan_tbl = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                   131071, 65535, 32767};
   end

   function automatic longint pixel_angle(input longint dx, input longint dy);
      longint x, y, z, t, xs, ys;
      if (dy == 0) return (dx < 0) ? longint'(PI_Q12) : 0;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      // fold the left half plane onto the right one
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = longint'(HALF_PI_Q30);
         end else begin
            t = x; x = -y; y = t; z = -longint'(HALF_PI_Q30);
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_tbl[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_tbl[i];
         end
      end
      z = (z + 131072) >>> 18;
      if (z > longint'(PI_Q12)) z = longint'(PI_Q12);
      if (z < -longint'(PI_Q12)) z = -longint'(PI_Q12);
      return z;
   endfunction

   function automatic logic signed [47:0] saturate(input logic neg, input logic [63:0] mag);
      if (mag > 64'h7fff_ffff_ffff) return neg ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
      return neg ? -$signed(mag[47:0]) : $signed(mag[47:0]);
   endfunction

   function automatic logic [63:0] floor_div(input logic [127:0] num, input logic [63:0] den);
      logic [127:0] q;
      q = num / {64'd0, den};
      return (q[127:64] != 0) ? '1 : q[63:0];
   endfunction

   function automatic logic signed [47:0] round_div(input logic neg, input logic [127:0] mag,
                                                     input logic [63:0] den);
      return saturate(neg, floor_div(mag + {65'd0, den[63:1]}, den));
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [127:0] x);
      logic [63:0]  r, c;
      logic [127:0] sq;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= x) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [47:0] image_statistic(input logic [15:0] norm,
                                                          output logic fault);
      logic [63:0]  c, sm, nd, r, wm;
      logic [127:0] qc, s2, dd;
      logic         sneg, dneg;
      longint       sv, w;
      c    = {39'd0, acc_count};
      sv   = longint'(acc_sum);
      sneg = sv < 0;
      sm   = sneg ? 64'(-sv) : 64'(sv);
      qc   = {70'd0, acc_sq} * {64'd0, c};
      s2   = {64'd0, sm} * {64'd0, sm};
      dneg = qc < s2;
      dd   = (qc - s2) << 32;
      nd   = (norm != 0) ? {48'd0, norm} : 64'd1;
      fault = 1'b0;
      case (cfg.moment_select)
         MOM_SUM: begin
            return round_div(sneg, {64'd0, sm} << 16, nd);
         end
         MOM_MEAN: begin
            if (c != 0) return round_div(sneg, {64'd0, sm} << 16, c * nd);
         end
         MOM_STD: begin
            if (c != 0 && !dneg) begin
               r = int_sqrt(dd) / c;
               if (norm != 0) r = (r + {49'd0, norm[15:1]}) / {48'd0, norm};
               return saturate(1'b0, r);
            end
         end
         MOM_CONTRAST: begin
            if (sm != 0 && !dneg) return saturate(1'b0, int_sqrt(dd) / sm);
         end
         MOM_XCENTER, MOM_YCENTER: begin
            if (sm != 0) begin
               w  = (cfg.moment_select == MOM_XCENTER) ? longint'(acc_cw) : longint'(acc_rw);
               wm = (w < 0) ? 64'(-w) : 64'(w);
               return round_div((w < 0) != sneg, {64'd0, wm} << 16, sm);
            end
         end
         default: begin
            return '0;
         end
      endcase
      fault = 1'b1;
      return '0;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < 40)
         $display("checker: %s mismatch on result %0d: got %0h, expected %0h",
                  field, results_seen, got, want);
      fail_count++;
   endtask

   task automatic take_pixel();
      longint         dx, dy, rsq, ang, lo, hi, v;
      image_stat_type s;
      if (!req_bus.masked_out) begin
         dx  = longint'(req_bus.column) * 16 + 8 - longint'(cfg.center_x);
         dy  = longint'(req_bus.row) * 16 + 8 - longint'(cfg.center_y);
         rsq = dx * dx + dy * dy;
         ang = pixel_angle(dx, dy);
         lo  = longint'(cfg.phi_low);
         hi  = longint'(cfg.phi_high);
         if (rsq >= longint'(cfg.inner_radius_sq) && rsq <= longint'(cfg.outer_radius_sq)
             && ((ang >= lo && ang <= hi) || (ang + longint'(TWO_PI_Q12) <= hi))) begin
            v = longint'(req_bus.raw_value) - longint'(cfg.pedestal);
            acc_count = acc_count + 1;
            acc_sum   = acc_sum + 41'(v);
            acc_sq    = acc_sq + 58'(v * v);
            acc_cw    = acc_cw + 54'(longint'(req_bus.column) * v);
            acc_rw    = acc_rw + 54'(longint'(req_bus.row) * v);
         end
      end
      if (req_bus.last_pixel) begin
         s.value = image_statistic(req_bus.norm_divisor, s.fault);
         s.count = acc_count;
         stat_q.push_back(s);
         acc_count = '0; acc_sum = '0; acc_sq = '0; acc_cw = '0; acc_rw = '0;
      end
   endtask

   always @(posedge clock) begin
      image_stat_type s;
      if (reset) begin
         cfg = '{center_x: 16'd0, center_y: 16'd0, inner_radius_sq: 33'd0,
                 outer_radius_sq: '1, phi_low: -17'sd12868, phi_high: 17'sd12868,
                 pedestal: 16'd0, moment_select: MOM_SUM};
         acc_count = '0; acc_sum = '0; acc_sq = '0; acc_cw = '0; acc_rw = '0;
         stat_q.delete();
         fail_count   = 0;
         results_seen = 0;
      end else begin
         if (csr_write) begin
            case (reg_index_type'(csr_index))
               REG_CENTER_X:  cfg.center_x        = csr_data[15:0];
               REG_CENTER_Y:  cfg.center_y        = csr_data[15:0];
               REG_INNER_RSQ: cfg.inner_radius_sq = csr_data;
               REG_OUTER_RSQ: cfg.outer_radius_sq = csr_data;
               REG_PHI_LOW:   cfg.phi_low         = csr_data[16:0];
               REG_PHI_HIGH:  cfg.phi_high        = csr_data[16:0];
               REG_PEDESTAL:  cfg.pedestal        = csr_data[15:0];
               REG_MOMENT:    cfg.moment_select   = csr_data[2:0];
               default: ;
            endcase
         end
         // check the outgoing result before a new last pixel can queue another
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (stat_q.size() == 0) begin
               report_mismatch("unexpected result", {16'd0, rsp_bus.result_value}, 64'd0);
            end else begin
               s = stat_q.pop_front();
               if (rsp_bus.result_value !== s.value)
                  report_mismatch("result_value", 64'(rsp_bus.result_value), 64'(s.value));
               if (rsp_bus.pixel_count !== s.count)
                  report_mismatch("pixel_count", 64'(rsp_bus.pixel_count), 64'(s.count));
               if (rsp_bus.math_fault !== s.fault)
                  report_mismatch("math_fault", 64'(rsp_bus.math_fault), 64'(s.fault));
            end
            results_seen++;
         end
         if (req_bus.valid && req_bus.ready) take_pixel();
      end
      pending = stat_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the annular sector pixel statistics unit.
// Streams directed and random images under several register settings and
// handshake idle patterns; a checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import asps_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [32:0] csr_data;
   int          fail_count, pending, results_seen;
   int          cycle, hold_end, stall_pct, idle_pct;
   int          sent_count, phase_count;

   asps_req_if req_bus();
   asps_rsp_if rsp_bus();

   annular_sector_pixel_statistics_unit #(.CORDIC_STAGES(16)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   asps_stats_checker stats_check (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // hold off entirely until hold_end, otherwise stall at random
   always @(posedge clock) begin
      rsp_bus.ready <= (cycle >= hold_end) && ($urandom_range(99) >= stall_pct);
   end

   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                             input logic [15:0] raw, input logic masked,
                             input logic last, input logic [15:0] norm);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.column       <= col;
      req_bus.row          <= row;
      req_bus.raw_value    <= raw;
      req_bus.masked_out   <= masked;
      req_bus.last_pixel   <= last;
      req_bus.norm_divisor <= norm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   // drain all results, then let the pipe run empty before touching registers
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [32:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic program_ring(input int cx, input int cy, input logic [32:0] rin,
                               input logic [32:0] rout, input int plo, input int phi,
                               input int ped, input int mode);
      write_reg(REG_CENTER_X, 33'(cx & 'hffff));
      write_reg(REG_CENTER_Y, 33'(cy & 'hffff));
      write_reg(REG_INNER_RSQ, rin);
      write_reg(REG_OUTER_RSQ, rout);
      write_reg(REG_PHI_LOW, 33'(plo & 'h1ffff));
      write_reg(REG_PHI_HIGH, 33'(phi & 'h1ffff));
      write_reg(REG_PEDESTAL, 33'(ped & 'hffff));
      write_reg(REG_MOMENT, 33'(mode & 7));
      csr_write <= 1'b0;
      phase_count++;
   endtask

   task automatic set_moment(input logic [2:0] mode);
      write_reg(REG_MOMENT, {30'd0, mode});
      csr_write <= 1'b0;
   endtask

   function automatic logic [11:0] near(input int centre, input int span);
      int p;
      p = centre + $urandom_range(0, 2 * span) - span;
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      return 12'(p);
   endfunction

   task automatic random_image(input int ccol, input int crow, input int span,
                               input int ped, input int npix);
      logic [15:0] raw, norm;
      int          k;
      k = $urandom_range(99);
      norm = (k < 40) ? 16'd0 : (k < 50) ? 16'hffff : 16'($urandom_range(1, 65535));
      for (int i = 0; i < npix; i++) begin
         raw = ($urandom_range(1)) ? 16'(ped + $urandom_range(0, 600) - 300)
                                   : 16'($urandom_range(0, 65535));
         if ($urandom_range(99) < 10)
            send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       16'($urandom_range(0, 65535)), 1'($urandom_range(1)),
                       i == npix - 1, norm);
         else
            send_pixel(near(ccol, span), near(crow, span), raw,
                       $urandom_range(99) < 8, i == npix - 1, norm);
      end
   endtask

   task automatic random_phase(input int p);
      int          cx, cy, span, ri, plo, phi, ped, mode, k, npix;
      logic [32:0] rin, rout;
      drain();
      k  = $urandom_range(99);
      cx = (k < 10) ? 0 : (k < 20) ? 65535 : $urandom_range(0, 65535);
      k  = $urandom_range(99);
      cy = (k < 10) ? 0 : (k < 20) ? 65535 : $urandom_range(0, 65535);
      span = $urandom_range(2, 40);
      ri   = $urandom_range(0, span - 1);
      rin  = 33'((ri * 16) * (ri * 16));
      rout = 33'((span * 16) * (span * 16) * $urandom_range(1, 2));
      k = $urandom_range(99);
      if (k < 15) begin
         rin = '0; rout = '1;
      end else if (k < 19) begin
         rin = '1; rout = '1;
      end
      k = $urandom_range(99);
      if (k < 70) begin
         plo = $urandom_range(0, 25736) - 12868;
         phi = plo + $urandom_range(0, 25736);
      end else if (k < 85) begin
         plo = $urandom_range(0, 12868);
         phi = $urandom_range(12868, 38604);
      end else begin
         plo = $urandom_range(0, 131071) - 65536;
         phi = $urandom_range(0, 131071) - 65536;
      end
      k   = $urandom_range(99);
      ped = (k < 30) ? 0 : (k < 40) ? 65535 : $urandom_range(0, 65535);
      mode = ($urandom_range(99) < 90) ? $urandom_range(0, 5) : $urandom_range(6, 7);
      program_ring(cx, cy, rin, rout, plo, phi, ped, mode);
      case (p % 4)
         0: begin idle_pct = 0;  stall_pct <= 0;  end
         1: begin idle_pct = 64; stall_pct <= 0;  end
         2: begin idle_pct = 0;  stall_pct <= 64; end
         default: begin idle_pct = 26; stall_pct <= 26; end
      endcase
      // long receiver hold-off while images keep streaming in
      if (p % 7 == 5) hold_end <= cycle + 900;
      for (int img = 0; img < 6; img++) begin
         npix = ($urandom_range(99) < 15) ? 1 : $urandom_range(2, 40);
         random_image(cx >> 4, cy >> 4, span + 2, ped, npix);
      end
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.column       = '0;
      req_bus.row          = '0;
      req_bus.raw_value    = '0;
      req_bus.masked_out   = 1'b0;
      req_bus.last_pixel   = 1'b0;
      req_bus.norm_divisor = '0;
      rsp_bus.ready        = 1'b0;
      csr_write            = 1'b0;
      csr_index            = '0;
      csr_data             = '0;
      cycle                = 0;
      hold_end             = 0;
      stall_pct            = 0;
      idle_pct             = 0;
      sent_count           = 0;
      phase_count          = 0;
      reset                = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // centre on pixel (100,100): zero offset, negative axis, field extremes
      program_ring(100 * 16 + 8, 100 * 16 + 8, '0, '1, -12868, 12868, 0, MOM_SUM);
      send_pixel(12'd100, 12'd100, 16'd500, 1'b0, 1'b0, 16'd0);
      send_pixel(12'd90, 12'd100, 16'd1000, 1'b0, 1'b0, 16'd0);
      send_pixel(12'd4095, 12'd4095, 16'hffff, 1'b0, 1'b0, 16'd0);
      send_pixel(12'd0, 12'd0, 16'd0, 1'b0, 1'b0, 16'd0);
      send_pixel(12'd50, 12'd60, 16'd1234, 1'b1, 1'b0, 16'd0);
      send_pixel(12'd101, 12'd100, 16'd7, 1'b0, 1'b1, 16'hffff);
      for (int m = 1; m < 8; m++) begin
         drain();
         set_moment(3'(m));
         send_pixel(12'd120, 12'd130, 16'($urandom_range(0, 65535)), 1'b0, 1'b0, 16'd0);
         send_pixel(12'd80, 12'd70, 16'($urandom_range(0, 65535)), 1'b0, 1'b1,
                    (m % 2) ? 16'd3 : 16'd0);
      end
      // mean over an empty image
      drain();
      set_moment(MOM_MEAN);
      send_pixel(12'd100, 12'd101, 16'd9, 1'b1, 1'b1, 16'd0);
      // upper limit beyond pi: angle plus two pi reaches it
      drain();
      program_ring(100 * 16 + 8, 100 * 16 + 8, '0, '1, 20000, 30000, 65535, MOM_SUM);
      send_pixel(12'd110, 12'd95, 16'd40000, 1'b0, 1'b0, 16'd0);
      send_pixel(12'd95, 12'd110, 16'd20, 1'b0, 1'b1, 16'd0);

      for (int p = 0; sent_count < 1200 || results_seen < 48; p++)
         random_phase(p);

      drain();
      repeat (100) @(posedge clock);
      $display("summary: %0d pixel requests, %0d images checked over %0d register settings",
               sent_count, results_seen, phase_count);
      $display("summary: %0d mismatches found", fail_count);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== annular_sector_pixel_statistics_unit.f =====
src/asps_pkg.sv
src/asps_req_if.sv
src/asps_rsp_if.sv
src/asps_front.sv
src/asps_queue.sv
src/asps_back.sv
src/annular_sector_pixel_statistics_unit.sv
tb/sv/asps_stats_checker.sv
tb/sv/tb.sv
